[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every edge outside reset
`define CHK_ALWAYS(lbl, clk_s, rst_s, expr) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (expr)) \
    else $error("check failed");

// Antecedent implies consequent, same edge or later per property text
`define CHK_IMPLIES(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("check failed");

`endif

[hw/rtl/vau_pkg.sv]
// Shared widths, operation codes and pipeline records for the vector unit
`default_nettype none
package vau_pkg;
  localparam int DATA_W      = 32;
  localparam int FRAC_W      = 16;
  localparam int OP_W        = 3;
  localparam int LANES       = 4;
  localparam int SQ_W        = 2 * DATA_W;
  localparam int SUM_W       = SQ_W + 2;
  localparam int ROOT_W      = SUM_W / 2;
  localparam int SQRT_STAGES = ROOT_W;
  localparam int NUM_W       = DATA_W + FRAC_W;
  localparam int DIV_STAGES  = NUM_W;
  localparam int DIVR_W      = ROOT_W;
  localparam int SIDE_DEPTH  = SQRT_STAGES + DIV_STAGES + 1;
  localparam int LATENCY     = 5 + SQRT_STAGES + DIV_STAGES;

  localparam logic [OP_W-1:0] OP_ADD  = 3'd0;
  localparam logic [OP_W-1:0] OP_SUB  = 3'd1;
  localparam logic [OP_W-1:0] OP_MUL  = 3'd2;
  localparam logic [OP_W-1:0] OP_DIV  = 3'd3;
  localparam logic [OP_W-1:0] OP_NORM = 3'd4;

  localparam logic [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    logic [DATA_W-1:0] res;
    logic              sat;
    logic [SQ_W-1:0]   sq;
    logic [DATA_W-1:0] amag;
    logic [DATA_W-1:0] bmag;
    logic              negq;
    logic              aneg;
    logic              azero;
    logic              bzero;
    logic [DATA_W-1:0] araw;
  } lane_out_t;

  typedef struct packed {
    logic [OP_W-1:0]              op;
    lane_out_t [LANES-1:0]        ln;
    logic                         lenz;
  } side_t;
endpackage
`default_nettype wire

[hw/rtl/vau_lane.sv]
// One component lane: add/sub/mul with clamping, square and magnitudes
`default_nettype none
module vau_lane (
  input  logic                                clk,
  input  logic [vau_pkg::OP_W-1:0]            op,
  input  logic signed [vau_pkg::DATA_W-1:0]   a,
  input  logic signed [vau_pkg::DATA_W-1:0]   b,
  output vau_pkg::lane_out_t                  lo
);
  import vau_pkg::*;

  logic [DATA_W-1:0]          a_mag, b_mag;
  logic signed [DATA_W:0]     sum_c;
  logic [OP_W-1:0]            op1;
  logic signed [DATA_W:0]     sum1;
  logic signed [2*DATA_W-1:0] prod1;
  logic [SQ_W-1:0]            sq1;
  logic [DATA_W-1:0]          amag1, bmag1, araw1;
  logic                       negq1, aneg1, azero1, bzero1;
  logic [DATA_W-1:0]          as_res, mul_res;
  logic                       as_ovf, mul_ovf;
  logic [2*DATA_W-1-(DATA_W+FRAC_W-1):0] prod_hi;
  lane_out_t                  lo_next;

  always_comb begin
    a_mag = a[DATA_W-1] ? (~a + 1'b1) : a;
    b_mag = b[DATA_W-1] ? (~b + 1'b1) : b;
    if (op == OP_SUB) begin
      sum_c = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    end else begin
      sum_c = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    end
  end

  always_ff @(posedge clk) begin
    op1    <= op;
    sum1   <= sum_c;
    prod1  <= a * b;
    sq1    <= a_mag * a_mag;
    amag1  <= a_mag;
    bmag1  <= b_mag;
    araw1  <= a;
    negq1  <= a[DATA_W-1] ^ b[DATA_W-1];
    aneg1  <= a[DATA_W-1];
    azero1 <= (a == '0);
    bzero1 <= (b == '0);
  end

  always_comb begin
    as_ovf  = sum1[DATA_W] ^ sum1[DATA_W-1];
    as_res  = as_ovf ? (sum1[DATA_W] ? Q_MIN : Q_MAX) : sum1[DATA_W-1:0];
    // floor shift keeps the top 17 bits; they must all agree
    prod_hi = prod1[2*DATA_W-1:DATA_W+FRAC_W-1];
    mul_ovf = !((&prod_hi) || (~|prod_hi));
    mul_res = mul_ovf ? (prod1[2*DATA_W-1] ? Q_MIN : Q_MAX)
                      : prod1[DATA_W+FRAC_W-1:FRAC_W];
    lo_next       = '0;
    lo_next.sq    = sq1;
    lo_next.amag  = amag1;
    lo_next.bmag  = bmag1;
    lo_next.araw  = araw1;
    lo_next.negq  = negq1;
    lo_next.aneg  = aneg1;
    lo_next.azero = azero1;
    lo_next.bzero = bzero1;
    case (op1) inside
      OP_ADD, OP_SUB: begin
        lo_next.res = as_res;
        lo_next.sat = as_ovf;
      end
      OP_MUL: begin
        lo_next.res = mul_res;
        lo_next.sat = mul_ovf;
      end
      default: begin
        lo_next.res = '0;
        lo_next.sat = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    lo <= lo_next;
  end
endmodule
`default_nettype wire

[hw/rtl/vau_sqrt.sv]
// Pipelined integer square root, one root bit per stage
`default_nettype none
module vau_sqrt (
  input  logic                         clk,
  input  logic [vau_pkg::SUM_W-1:0]    rad,
  output logic [vau_pkg::ROOT_W-1:0]   root
);
  import vau_pkg::*;

  localparam int REM_W = ROOT_W + 3;

  logic [SUM_W-1:0]  rad_q  [SQRT_STAGES];
  logic [REM_W-1:0]  rem_q  [SQRT_STAGES];
  logic [ROOT_W-1:0] root_q [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    logic [SUM_W-1:0]  rad_i;
    logic [REM_W-1:0]  rem_i, cur, trial;
    logic [ROOT_W-1:0] root_i;
    logic              ge;
    if (k == 0) begin : g_first
      assign rad_i  = rad;
      assign rem_i  = '0;
      assign root_i = '0;
    end else begin : g_next
      assign rad_i  = rad_q[k-1];
      assign rem_i  = rem_q[k-1];
      assign root_i = root_q[k-1];
    end
    assign cur   = {rem_i[REM_W-3:0], rad_i[SUM_W-1 -: 2]};
    assign trial = REM_W'({root_i, 2'b01});
    assign ge    = (cur >= trial);
    always_ff @(posedge clk) begin
      rad_q[k]  <= rad_i << 2;
      rem_q[k]  <= ge ? (cur - trial) : cur;
      root_q[k] <= {root_i[ROOT_W-2:0], ge};
    end
  end

  assign root = root_q[SQRT_STAGES-1];
endmodule
`default_nettype wire

[hw/rtl/vau_div.sv]
// Pipelined restoring divider, one quotient bit per stage
`default_nettype none
module vau_div (
  input  logic                         clk,
  input  logic [vau_pkg::NUM_W-1:0]    num,
  input  logic [vau_pkg::DIVR_W-1:0]   den,
  output logic [vau_pkg::NUM_W-1:0]    quo
);
  import vau_pkg::*;

  logic [NUM_W-1:0]  nq_q  [DIV_STAGES];
  logic [DIVR_W-1:0] rem_q [DIV_STAGES];
  logic [DIVR_W-1:0] den_q [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [NUM_W-1:0]  nq_i;
    logic [DIVR_W-1:0] rem_i, den_i;
    logic [DIVR_W:0]   cur, dif;
    logic              ge;
    if (k == 0) begin : g_first
      assign nq_i  = num;
      assign rem_i = '0;
      assign den_i = den;
    end else begin : g_next
      assign nq_i  = nq_q[k-1];
      assign rem_i = rem_q[k-1];
      assign den_i = den_q[k-1];
    end
    assign cur = {rem_i, nq_i[NUM_W-1]};
    assign ge  = (cur >= {1'b0, den_i});
    assign dif = cur - {1'b0, den_i};
    always_ff @(posedge clk) begin
      nq_q[k]  <= {nq_i[NUM_W-2:0], ge};
      rem_q[k] <= ge ? dif[DIVR_W-1:0] : cur[DIVR_W-1:0];
      den_q[k] <= den_i;
    end
  end

  assign quo = nq_q[DIV_STAGES-1];
endmodule
`default_nettype wire

[hw/rtl/vec4_arith_normalize_unit_core.sv]
// Top level: four-lane Q16.16 vector ALU with normalize
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  command  | start / busy         | operation, a_x..a_w, b_x..b_w
//  result   | done (strobe)        | r_x..r_w, saturated, divided_by_zero
//
// One beat accepted per cycle; busy stays low. Every command, whatever its
// operation, passes five register stages plus the 33-stage root pipeline and
// the 48-stage per-lane divider before its result beat. done marks that beat
// and lasts one cycle.
// Synchronous reset clears the valid chain and done; in-flight beats are lost.
// Results are not held: done lasts one cycle and cannot be stalled.
`default_nettype none
module vec4_arith_normalize_unit_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [vau_pkg::OP_W-1:0]           operation,
  input  logic signed [vau_pkg::DATA_W-1:0]  a_x,
  input  logic signed [vau_pkg::DATA_W-1:0]  a_y,
  input  logic signed [vau_pkg::DATA_W-1:0]  a_z,
  input  logic signed [vau_pkg::DATA_W-1:0]  a_w,
  input  logic signed [vau_pkg::DATA_W-1:0]  b_x,
  input  logic signed [vau_pkg::DATA_W-1:0]  b_y,
  input  logic signed [vau_pkg::DATA_W-1:0]  b_z,
  input  logic signed [vau_pkg::DATA_W-1:0]  b_w,
  output logic                               done,
  output logic signed [vau_pkg::DATA_W-1:0]  r_x,
  output logic signed [vau_pkg::DATA_W-1:0]  r_y,
  output logic signed [vau_pkg::DATA_W-1:0]  r_z,
  output logic signed [vau_pkg::DATA_W-1:0]  r_w,
  output logic                               saturated,
  output logic                               divided_by_zero
);
  import vau_pkg::*;

  logic                     vld0, vld1, vld2;
  logic [OP_W-1:0]          op0, op1, op2;
  logic [DATA_W-1:0]        a_q [LANES];
  logic [DATA_W-1:0]        b_q [LANES];
  lane_out_t                lane_o [LANES];
  logic [SUM_W-1:0]         sum_q;
  side_t                    side_q [SIDE_DEPTH];
  logic [SIDE_DEPTH-1:0]    side_vld;
  logic [ROOT_W-1:0]        root;
  logic [NUM_W-1:0]         quo [LANES];
  logic [DATA_W-1:0]        res_c [LANES];
  logic [LANES-1:0]         sat_c, dz_c;
  side_t                    fin;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld0     <= 1'b0;
      vld1     <= 1'b0;
      vld2     <= 1'b0;
      side_vld <= '0;
      done     <= 1'b0;
    end else begin
      vld0     <= start && !busy;
      vld1     <= vld0;
      vld2     <= vld1;
      side_vld <= {side_vld[SIDE_DEPTH-2:0], vld2};
      done     <= side_vld[SIDE_DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op0    <= operation;
      a_q[0] <= a_x;
      a_q[1] <= a_y;
      a_q[2] <= a_z;
      a_q[3] <= a_w;
      b_q[0] <= b_x;
      b_q[1] <= b_y;
      b_q[2] <= b_z;
      b_q[3] <= b_w;
    end
    op1 <= op0;
    op2 <= op1;
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    vau_lane u_lane (
      .clk (clk),
      .op  (op0),
      .a   (a_q[i]),
      .b   (b_q[i]),
      .lo  (lane_o[i])
    );
  end

  always_ff @(posedge clk) begin
    sum_q <= SUM_W'(lane_o[0].sq) + SUM_W'(lane_o[1].sq)
           + SUM_W'(lane_o[2].sq) + SUM_W'(lane_o[3].sq);
    side_q[0].op   <= op2;
    side_q[0].lenz <= 1'b0;
    for (int i = 0; i < LANES; i++) begin
      side_q[0].ln[i] <= lane_o[i];
    end
    for (int k = 1; k < SIDE_DEPTH; k++) begin
      side_q[k].op <= side_q[k-1].op;
      side_q[k].ln <= side_q[k-1].ln;
      // root leaves the sqrt pipe level with slot SQRT_STAGES
      side_q[k].lenz <= (k == SQRT_STAGES + 1) ? (root == '0) : side_q[k-1].lenz;
    end
  end

  vau_sqrt u_sqrt (
    .clk  (clk),
    .rad  (sum_q),
    .root (root)
  );

  for (genvar i = 0; i < LANES; i++) begin : g_div
    logic [DIVR_W-1:0] den;
    assign den = (side_q[SQRT_STAGES].op == OP_DIV)
               ? DIVR_W'(side_q[SQRT_STAGES].ln[i].bmag) : root;
    vau_div u_div (
      .clk (clk),
      .num ({side_q[SQRT_STAGES].ln[i].amag, {FRAC_W{1'b0}}}),
      .den (den),
      .quo (quo[i])
    );
  end

  // merge: per-lane selection, then OR the flags across lanes
  assign fin = side_q[SIDE_DEPTH-1];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      res_c[i] = '0;
      sat_c[i] = 1'b0;
      dz_c[i]  = 1'b0;
      case (fin.op) inside
        OP_ADD, OP_SUB, OP_MUL: begin
          res_c[i] = fin.ln[i].res;
          sat_c[i] = fin.ln[i].sat;
        end
        OP_DIV: begin
          if (fin.ln[i].bzero) begin
            dz_c[i] = 1'b1;
            if (fin.ln[i].azero) begin
              res_c[i] = '0;
            end else begin
              res_c[i] = fin.ln[i].aneg ? Q_MIN : Q_MAX;
            end
          end else if (fin.ln[i].negq) begin
            if ((quo[i][NUM_W-1:DATA_W] != '0)
                || (quo[i][DATA_W-1] && (quo[i][DATA_W-2:0] != '0))) begin
              res_c[i] = Q_MIN;
              sat_c[i] = 1'b1;
            end else begin
              res_c[i] = ~quo[i][DATA_W-1:0] + 1'b1;
            end
          end else begin
            if (quo[i][NUM_W-1:DATA_W-1] != '0) begin
              res_c[i] = Q_MAX;
              sat_c[i] = 1'b1;
            end else begin
              res_c[i] = quo[i][DATA_W-1:0];
            end
          end
        end
        OP_NORM: begin
          if (fin.lenz) begin
            res_c[i] = fin.ln[i].araw;
          end else if (fin.ln[i].aneg) begin
            res_c[i] = ~quo[i][DATA_W-1:0] + 1'b1;
          end else begin
            res_c[i] = quo[i][DATA_W-1:0];
          end
        end
        default: begin
          res_c[i] = '0;
        end
      endcase
    end
  end

  // flags only show alongside a live result beat
  always_ff @(posedge clk) begin
    r_x             <= res_c[0];
    r_y             <= res_c[1];
    r_z             <= res_c[2];
    r_w             <= res_c[3];
    saturated       <= side_vld[SIDE_DEPTH-1] && (|sat_c);
    divided_by_zero <= side_vld[SIDE_DEPTH-1] && (|dz_c);
  end
endmodule
`default_nettype wire

[hw/rtl/vau_checker.sv]
// Port-level checker for the vector unit, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module vau_checker (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic busy,
  input  logic done,
  input  logic saturated,
  input  logic divided_by_zero
);
  import vau_pkg::*;

  `CHK_IMPLIES(a_done_follows, clk, rst, start && !busy, ##LATENCY done)
  `CHK_IMPLIES(a_done_has_cmd, clk, rst, done, $past(start && !busy && !rst, LATENCY))
  `CHK_ALWAYS(a_never_busy, clk, rst, !busy)
  `CHK_IMPLIES(a_flags_with_done, clk, rst, saturated || divided_by_zero, done)
endmodule

bind vec4_arith_normalize_unit_core vau_checker u_vau_checker (
  .clk             (clk),
  .rst             (rst),
  .start           (start),
  .busy            (busy),
  .done            (done),
  .saturated       (saturated),
  .divided_by_zero (divided_by_zero)
);
`default_nettype wire
